FILE: hdl/assert_macros.svh
// Assertion macros used by the mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons)
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/agm_pkg.sv
// Shared widths, constants and types of the adaptive gain mixer.
`timescale 1ns / 1ps

package agm_pkg;

   localparam int SAMPLE_W         = 16;
   localparam int CH_NUM           = 8;
   localparam int CFG_W            = 4;
   localparam int SUM_W            = 20;
   localparam int MAG_W            = 19;
   localparam int GAIN_W           = 17;
   localparam int FRAC_W           = 16;
   localparam int QUOT_W           = 16;
   localparam int RECOVER_SHIFT    = 5;
   localparam int MAX_CHANNELS_DEF = 8;

   localparam logic [CFG_W-1:0]    ACTIVE_RESET = 4'd2;
   localparam logic [GAIN_W-1:0]   GAIN_ONE     = 17'h10000;
   localparam logic [MAG_W-1:0]    POS_LIMIT    = 19'd32767;
   localparam logic [MAG_W-1:0]    NEG_LIMIT    = 19'd32768;
   localparam logic [SAMPLE_W-1:0] OUT_MAX      = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] OUT_MIN      = 16'h8000;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef sample_type [CH_NUM-1:0]    frame_type;

endpackage

FILE: hdl/agm_sum.sv
// Channel summer: shifts one channel word per cycle into an accumulator.
`timescale 1ns / 1ps

module agm_sum import agm_pkg::*; #(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  frame_type               frame,
   input  logic [CFG_W-1:0]        active_channels,
   output logic                    done,
   output logic signed [SUM_W-1:0] sum
);

   localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CHANNELS - 1);
   localparam logic [CFG_W-1:0] MAX_CFG  = CFG_W'(MAX_CHANNELS);

   sample_type               chan_ff [MAX_CHANNELS];
   sample_type               chan_in [MAX_CHANNELS];
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic signed [SUM_W-1:0]  acc_ff, acc_in;
   logic [CFG_W-1:0]         n_eff;
   logic signed [SUM_W-1:0]  head_ext;

   // Saturate the channel count to the number of lanes built
   assign n_eff    = (active_channels > MAX_CFG) ? MAX_CFG : active_channels;
   assign head_ext = {{(SUM_W - SAMPLE_W){chan_ff[0][SAMPLE_W-1]}}, chan_ff[0]};

   // Load the frame on start, otherwise advance the shift line by one word
   for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_line
      if (i < MAX_CHANNELS - 1) begin : g_mid
         assign chan_in[i] = start ? frame[i] : chan_ff[i+1];
      end else begin : g_end
         assign chan_in[i] = start ? frame[i] : '0;
      end
   end

   // Accumulate the head word while it belongs to an active channel
   always_comb begin
      idx_in  = idx_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      acc_in  = acc_ff;
      if (start) begin
         idx_in  = '0;
         busy_in = 1'b1;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (CFG_W'(idx_ff) < n_eff) begin
            acc_in = acc_ff + head_ext;
         end
         idx_in = idx_ff + IDX_W'(1);
         if (idx_ff == LAST_IDX) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      acc_ff <= acc_in;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         chan_ff[i] <= chan_in[i];
      end
   end

   assign done = done_ff;
   assign sum  = acc_ff;

endmodule

FILE: hdl/agm_mul.sv
// Bit-serial shift-add multiplier: magnitude times gain, one gain bit per cycle.
`timescale 1ns / 1ps

module agm_mul import agm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MAG_W-1:0]  mag,
   input  logic [GAIN_W-1:0] gain,
   output logic              done,
   output logic [MAG_W-1:0]  scaled
);

   localparam int ACC_W = MAG_W + GAIN_W;
   localparam int CNT_W = $clog2(GAIN_W);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(GAIN_W - 1);

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [MAG_W-1:0] mcand_ff, mcand_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [MAG_W:0]   upper_sum;

   // Add the multiplicand into the upper half when the low multiplier bit is set
   assign upper_sum = {1'b0, acc_ff[ACC_W-1:GAIN_W]}
                    + (acc_ff[0] ? {1'b0, mcand_ff} : '0);

   always_comb begin
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         acc_in   = {{MAG_W{1'b0}}, gain};
         mcand_in = mag;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in = {upper_sum, acc_ff[GAIN_W-1:1]};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_CNT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      cnt_ff   <= cnt_in;
   end

   // Drop the Q16 fraction of the product
   assign scaled = acc_ff[FRAC_W+MAG_W-1:FRAC_W];
   assign done   = done_ff;

endmodule

FILE: hdl/agm_div.sv
// Restoring divider: (limit << 16) / divisor, one quotient bit per cycle.
`timescale 1ns / 1ps

module agm_div import agm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MAG_W-1:0]  limit,
   input  logic [MAG_W-1:0]  divisor,
   output logic              done,
   output logic [QUOT_W-1:0] quotient
);

   localparam int CNT_W = $clog2(QUOT_W);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(QUOT_W - 1);

   logic [MAG_W-1:0]  rem_ff, rem_in;
   logic [MAG_W-1:0]  dvs_ff, dvs_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [MAG_W:0]    shifted;
   logic [MAG_W:0]    diff;
   logic              fits;

   // The limit is below the divisor, so the remainder always stays below it;
   // the low dividend bits are zero and only a shift enters each step
   assign shifted = {rem_ff, 1'b0};
   assign fits    = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = limit;
         dvs_in  = divisor;
         quot_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_CNT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

endmodule

FILE: hdl/adaptive_gain_audio_mixer_top.sv
// Adaptive gain audio mixer: control sequencer, gain state and channel ports.
`timescale 1ns / 1ps
//
// Usage
//   req_*: one sample frame per transaction (eight signed 16-bit channels and
//   a last-of-block flag). rsp_*: one mixed sample and a clipped flag for each
//   accepted frame, in order. csr_*: writes the active channel count; always
//   ready; the user must write it only while the mixer is idle; not enforced.
// Timing
//   A frame runs through three serial units in turn: the channel summer (one
//   channel per cycle), the shift-add multiplier (one gain bit per cycle) and,
//   only on a clipped sample, the restoring divider (one quotient bit per
//   cycle). A new frame is taken only after the previous result has been
//   handed off to the output register.
// Reset
//   Gain returns to 1.0 and the active channel count to 2; no result pending.
// Backpressure
//   A finished result waits in the output register; the next frame is
//   accepted and processed meanwhile and holds only in its own final state.
`include "assert_macros.svh"

module adaptive_gain_audio_mixer_top import agm_pkg::*; #(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CFG_W-1:0]           csr_active_channels,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_0,
   input  logic signed [SAMPLE_W-1:0] req_sample_1,
   input  logic signed [SAMPLE_W-1:0] req_sample_2,
   input  logic signed [SAMPLE_W-1:0] req_sample_3,
   input  logic signed [SAMPLE_W-1:0] req_sample_4,
   input  logic signed [SAMPLE_W-1:0] req_sample_5,
   input  logic signed [SAMPLE_W-1:0] req_sample_6,
   input  logic signed [SAMPLE_W-1:0] req_sample_7,
   input  logic                       req_last_of_block,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_mixed_sample,
   output logic                       rsp_clipped
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SUM  = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   localparam logic [GAIN_W-1:0] RECOVER_ROUND = GAIN_W'((1 << RECOVER_SHIFT) - 1);

   state_type               state_ff, state_in;
   logic [CFG_W-1:0]        active_ff;
   logic [GAIN_W-1:0]       gain_ff;
   logic                    rsp_valid_ff;
   logic [SAMPLE_W-1:0]     rsp_sample_ff;
   logic                    rsp_clipped_ff;
   logic                    last_ff;
   logic                    neg_ff;
   logic [SAMPLE_W-1:0]     res_ff;
   logic                    clip_ff;

   frame_type               frame;
   logic                    sum_start, sum_done;
   logic signed [SUM_W-1:0] sum_val;
   logic signed [SUM_W-1:0] abs_sum;
   logic [MAG_W-1:0]        sum_mag;
   logic                    mul_start, mul_done;
   logic [MAG_W-1:0]        scaled;
   logic [SAMPLE_W-1:0]     scaled_lo;
   logic                    over;
   logic                    div_start, div_done;
   logic [QUOT_W-1:0]       quotient;
   logic                    rsp_load;

   // Move the gain 1/32 of its distance back toward 1.0, rounding the step up
   function automatic logic [GAIN_W-1:0] recover(input logic [GAIN_W-1:0] g);
      logic [GAIN_W-1:0] step;
      step = ((GAIN_ONE - g) + RECOVER_ROUND) >> RECOVER_SHIFT;
      return (g < GAIN_ONE) ? g + step : g;
   endfunction

   assign frame = {req_sample_7, req_sample_6, req_sample_5, req_sample_4,
                   req_sample_3, req_sample_2, req_sample_1, req_sample_0};

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);

   // Sign and magnitude of the channel sum
   assign abs_sum = sum_val[SUM_W-1] ? -sum_val : sum_val;
   assign sum_mag = abs_sum[MAG_W-1:0];

   // Overflow test against the limit of the sum's sign
   assign scaled_lo = scaled[SAMPLE_W-1:0];
   assign over      = neg_ff ? (scaled > NEG_LIMIT) : (scaled > POS_LIMIT);

   agm_sum #(
      .MAX_CHANNELS(MAX_CHANNELS)
   ) u_sum (
      .clock          (clock),
      .reset          (reset),
      .start          (sum_start),
      .frame          (frame),
      .active_channels(active_ff),
      .done           (sum_done),
      .sum            (sum_val)
   );

   agm_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .mag   (sum_mag),
      .gain  (gain_ff),
      .done  (mul_done),
      .scaled(scaled)
   );

   agm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .limit   (neg_ff ? NEG_LIMIT : POS_LIMIT),
      .divisor (scaled),
      .done    (div_done),
      .quotient(quotient)
   );

   // Sequence sum, multiply, optional divide and result hand-off
   always_comb begin
      state_in  = state_ff;
      sum_start = 1'b0;
      mul_start = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sum_start = 1'b1;
               state_in  = ST_SUM;
            end
         end
         ST_SUM: begin
            if (sum_done) begin
               mul_start = 1'b1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               if (over) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state, configuration, gain and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= ACTIVE_RESET;
         gain_ff      <= GAIN_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            active_ff <= csr_active_channels;
         end
         if (state_ff == ST_DIV && div_done) begin
            gain_ff <= {1'b0, quotient};
         end else if (rsp_load) begin
            gain_ff <= last_ff ? GAIN_ONE : recover(gain_ff);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold per-frame payload and the finished result
   always_ff @(posedge clock) begin
      if (sum_start) begin
         last_ff <= req_last_of_block;
      end
      if (mul_start) begin
         neg_ff <= sum_val[SUM_W-1];
      end
      if (state_ff == ST_MUL && mul_done) begin
         clip_ff <= over;
         if (over) begin
            res_ff <= neg_ff ? OUT_MIN : OUT_MAX;
         end else begin
            res_ff <= neg_ff ? (~scaled_lo) + SAMPLE_W'(1) : scaled_lo;
         end
      end
      if (rsp_load) begin
         rsp_sample_ff  <= res_ff;
         rsp_clipped_ff <= clip_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mixed_sample = rsp_sample_ff;
   assign rsp_clipped      = rsp_clipped_ff;

   // A clipped result always sits at one of the two rails
   `ASSERT_SAME_CYCLE(a_clip_rail, clock, reset, rsp_valid && rsp_clipped, rsp_mixed_sample == OUT_MAX || rsp_mixed_sample == OUT_MIN)
   // The divider runs only after an overflow was seen
   `ASSERT_SAME_CYCLE(a_div_on_clip, clock, reset, state_ff == ST_DIV, clip_ff)
   // The gain is back at 1.0 after the last sample of a block
   `ASSERT_NEXT_CYCLE(a_block_reset, clock, reset, rsp_load && last_ff, gain_ff == GAIN_ONE)
   // An accepted frame blocks the input until its result is handed off
   `ASSERT_NEXT_CYCLE(a_one_frame, clock, reset, req_valid && req_ready, !req_ready)

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the adaptive gain audio mixer.
`timescale 1ns / 1ps

module testbench;
   import agm_pkg::*;

   localparam int SETTLE_CYCLES = 60;
   localparam int LONG_HOLD     = 300;
   localparam int PHASE_FRAMES  = 135;

   typedef struct packed {
      sample_type mixed;
      logic       clipped;
   } mix_result_type;

   // Tracks the mixer gain and holds the expected mix for every accepted frame.
   class gain_scoreboard;
      mix_result_type    expected_mix_q[$];
      logic [GAIN_W-1:0] gain;
      logic [CFG_W-1:0]  channel_count;
      int unsigned       mismatches;

      function new();
         gain          = GAIN_ONE;
         channel_count = ACTIVE_RESET;
         mismatches    = 0;
      endfunction

      function void write_channel_count(logic [CFG_W-1:0] value);
         channel_count = value;
      endfunction

      function int pending();
         return expected_mix_q.size();
      endfunction

      // Sum the active channels, scale by the running gain, clamp and adapt.
      function void note_frame(frame_type frame, logic last);
         int unsigned       used;
         int                acc;
         logic              neg;
         longint unsigned   mag;
         longint unsigned   scaled;
         longint unsigned   g;
         mix_result_type    mix;
         used = (channel_count > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : channel_count;
         acc  = 0;
         for (int k = 0; k < CH_NUM; k++) begin
            if (k < used) acc += int'($signed(frame[k]));
         end
         neg    = (acc < 0);
         mag    = neg ? longint'(-acc) : longint'(acc);
         scaled = (mag * gain) >> FRAC_W;
         g      = gain;
         mix.clipped = 1'b0;
         if (!neg) begin
            if (scaled > POS_LIMIT) begin
               g           = (longint'(POS_LIMIT) << FRAC_W) / scaled;
               mix.mixed   = OUT_MAX;
               mix.clipped = 1'b1;
            end else begin
               mix.mixed = sample_type'(scaled);
            end
         end else begin
            if (scaled > NEG_LIMIT) begin
               g           = (longint'(NEG_LIMIT) << FRAC_W) / scaled;
               mix.mixed   = OUT_MIN;
               mix.clipped = 1'b1;
            end else begin
               mix.mixed = sample_type'(-longint'(scaled));
            end
         end
         // Recover toward unity, rounding the step up.
         if (g < GAIN_ONE)
            g = g + ((GAIN_ONE - g + ((1 << RECOVER_SHIFT) - 1)) >> RECOVER_SHIFT);
         if (g > GAIN_ONE) g = GAIN_ONE;
         if (last) g = GAIN_ONE;
         gain = g[GAIN_W-1:0];
         expected_mix_q.push_back(mix);
      endfunction

      task report_mismatch(string msg);
         if (mismatches < 40) $display("MISMATCH at %0t: %s", $time, msg);
         mismatches++;
      endtask

      task check_result(sample_type mixed, logic clipped);
         mix_result_type want;
         if (expected_mix_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d clipped %0b", mixed, clipped));
         end else begin
            want = expected_mix_q.pop_front();
            if (mixed !== want.mixed)
               report_mismatch($sformatf("mixed_sample %0d, want %0d", mixed, want.mixed));
            if (clipped !== want.clipped)
               report_mismatch($sformatf("clipped %0b, want %0b", clipped, want.clipped));
         end
      endtask
   endclass

   logic                       clock;
   logic                       reset;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CFG_W-1:0]           csr_active_channels;
   logic                       req_valid;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_0;
   logic signed [SAMPLE_W-1:0] req_sample_1;
   logic signed [SAMPLE_W-1:0] req_sample_2;
   logic signed [SAMPLE_W-1:0] req_sample_3;
   logic signed [SAMPLE_W-1:0] req_sample_4;
   logic signed [SAMPLE_W-1:0] req_sample_5;
   logic signed [SAMPLE_W-1:0] req_sample_6;
   logic signed [SAMPLE_W-1:0] req_sample_7;
   logic                       req_last_of_block;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [SAMPLE_W-1:0] rsp_mixed_sample;
   logic                       rsp_clipped;

   gain_scoreboard sb = new();
   int             rsp_idle_pct;
   logic           long_hold_req;

   adaptive_gain_audio_mixer_top dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_active_channels (csr_active_channels),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sample_0        (req_sample_0),
      .req_sample_1        (req_sample_1),
      .req_sample_2        (req_sample_2),
      .req_sample_3        (req_sample_3),
      .req_sample_4        (req_sample_4),
      .req_sample_5        (req_sample_5),
      .req_sample_6        (req_sample_6),
      .req_sample_7        (req_sample_7),
      .req_last_of_block   (req_last_of_block),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_mixed_sample    (rsp_mixed_sample),
      .rsp_clipped         (rsp_clipped)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Give up on a hung run.
   initial begin
      #1400000;
      $display("CHECK FAILED");
      $finish;
   end

   // Check every result transaction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_mixed_sample, rsp_clipped);
   end

   // Drive rsp_ready: random stall bursts, plus one long hold on request.
   initial begin : result_sink
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold          = LONG_HOLD;
         end
         if (hold > 0) begin
            rsp_ready = 1'b0;
            hold--;
         end else if (rsp_idle_pct > 0 && $urandom_range(99) < rsp_idle_pct) begin
            rsp_ready = 1'b0;
            hold      = $urandom_range(14, 1) - 1;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   function automatic frame_type uniform_frame(int value);
      frame_type f;
      for (int k = 0; k < CH_NUM; k++) f[k] = value[SAMPLE_W-1:0];
      return f;
   endfunction

   // Pick a frame: loud same-sign, full random, quiet, or extreme values.
   function automatic frame_type random_frame();
      frame_type   f;
      int          v;
      int unsigned style;
      logic        neg;
      style = $urandom_range(99);
      neg   = 1'($urandom_range(1));
      for (int k = 0; k < CH_NUM; k++) begin
         if (style < 35) begin
            v = neg ? -int'($urandom_range(32768, 12000)) : int'($urandom_range(32767, 12000));
         end else if (style < 65) begin
            v = int'($urandom);
         end else if (style < 85) begin
            v = int'($urandom_range(2047)) - 1024;
         end else begin
            case ($urandom_range(4))
               0: v = 32767;
               1: v = -32768;
               2: v = 1;
               3: v = -1;
               default: v = 0;
            endcase
         end
         f[k] = v[SAMPLE_W-1:0];
      end
      return f;
   endfunction

   // Offer one frame after an optional idle burst and wait for the transaction.
   task automatic send_frame(frame_type frame, logic last, int idle_pct);
      int gap;
      gap = 0;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) gap = $urandom_range(14, 1);
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_sample_0      = frame[0];
      req_sample_1      = frame[1];
      req_sample_2      = frame[2];
      req_sample_3      = frame[3];
      req_sample_4      = frame[4];
      req_sample_5      = frame[5];
      req_sample_6      = frame[6];
      req_sample_7      = frame[7];
      req_last_of_block = last;
      req_valid         = 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_frame(frame, last);
   endtask

   // Drop valid and wait until every outstanding mix has come back.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_channel_count(logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_active_channels = value;
      csr_valid           = 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.write_channel_count(value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin : stimulus
      logic [CFG_W-1:0] phase_counts [14];
      int               idle_levels [4];
      frame_type        f;
      int               block_left;
      int               send_idle;
      logic             last;

      phase_counts = '{4'd8, 4'd1, 4'd3, 4'd8, 4'd15, 4'd0, 4'd5,
                       4'd2, 4'd7, 4'd8, 4'd9, 4'd4, 4'd6, 4'd8};
      idle_levels  = '{30, 0, 60, 15};

      reset               = 1'b1;
      csr_valid           = 1'b0;
      csr_active_channels = ACTIVE_RESET;
      req_valid           = 1'b0;
      req_sample_0        = '0;
      req_sample_1        = '0;
      req_sample_2        = '0;
      req_sample_3        = '0;
      req_sample_4        = '0;
      req_sample_5        = '0;
      req_sample_6        = '0;
      req_sample_7        = '0;
      req_last_of_block   = 1'b0;
      rsp_ready           = 1'b0;
      rsp_idle_pct        = 0;
      long_hold_req       = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: two channels at reset, full-scale edges, clip and recovery.
      send_frame(uniform_frame(0), 1'b0, 0);
      f = uniform_frame(0);
      f[0] = 16'sh7FFF;
      send_frame(f, 1'b0, 0);
      f[0] = 16'sh8000;
      send_frame(f, 1'b0, 0);
      send_frame(uniform_frame(32767), 1'b0, 0);
      send_frame(uniform_frame(1000), 1'b0, 0);
      send_frame(uniform_frame(-32768), 1'b1, 0);
      f = uniform_frame(-1);
      f[0] = 16'sd1000;
      send_frame(f, 1'b0, 0);
      drain();

      // All eight channels: both clip directions and alternating bit patterns.
      write_channel_count(4'd8);
      send_frame(uniform_frame(32767), 1'b0, 0);
      send_frame(uniform_frame(-32768), 1'b0, 0);
      for (int k = 0; k < CH_NUM; k++) f[k] = (k % 2 == 0) ? 16'h5555 : 16'hAAAA;
      send_frame(f, 1'b0, 0);
      for (int k = 0; k < CH_NUM; k++) f[k] = (k % 2 == 0) ? 16'hAAAA : 16'h5555;
      send_frame(f, 1'b0, 0);
      send_frame(uniform_frame(-1), 1'b1, 0);
      send_frame(uniform_frame(100), 1'b0, 0);
      drain();

      // Zero channels mix to silence.
      write_channel_count(4'd0);
      send_frame(uniform_frame(32767), 1'b0, 0);
      send_frame(uniform_frame(-32768), 1'b1, 0);
      drain();

      // Counts above the channel limit saturate.
      write_channel_count(4'd15);
      send_frame(uniform_frame(32767), 1'b0, 0);
      send_frame(uniform_frame(4096), 1'b1, 0);
      drain();

      write_channel_count(4'd1);
      send_frame(uniform_frame(-32768), 1'b0, 0);
      send_frame(uniform_frame(32767), 1'b1, 0);
      drain();

      // Random phases: blocks of random length, a little end-of-block noise.
      block_left = 0;
      for (int p = 0; p < 14; p++) begin
         write_channel_count(phase_counts[p]);
         if (p == 13) begin
            send_idle    = 0;
            rsp_idle_pct = 0;
         end else begin
            send_idle    = idle_levels[p % 4];
            rsp_idle_pct = idle_levels[(p + 1) % 4];
         end
         if (p == 2) long_hold_req = 1'b1;
         for (int i = 0; i < PHASE_FRAMES; i++) begin
            if (block_left == 0) block_left = $urandom_range(48, 1);
            last = (block_left == 1);
            block_left--;
            if ($urandom_range(99) < 3) last = ~last;
            send_frame(random_frame(), last, send_idle);
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/agm_pkg.sv
hdl/agm_sum.sv
hdl/agm_mul.sv
hdl/agm_div.sv
hdl/adaptive_gain_audio_mixer_top.sv
dv/testbench.sv
